FILE: src/nrf_pkg.sv
package nrf_pkg;

	// One beat of the incoming record stream
	typedef struct packed {
		logic [15:0] record_word;
		logic        final_word;
	} rec_beat_t;

	// One beat of the fixed record stream
	typedef struct packed {
		logic [15:0] fixed_word;
		logic        final_out;
		logic [2:0]  fixup_status;
	} fix_beat_t;

	// Status codes reported on the last beat of a record
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NO_FILE   = 3'd1;
	localparam logic [2:0] ST_ALLOC     = 3'd2;
	localparam logic [2:0] ST_MISMATCH  = 3'd3;
	localparam logic [2:0] ST_BAD_ARRAY = 3'd4;

	// "FI" and "LE" as little-endian words
	localparam logic [15:0] SIG_WORD0 = 16'h4946;
	localparam logic [15:0] SIG_WORD1 = 16'h454C;

	// Words of the fixed header layout
	localparam int HEADER_WORDS = 16;

	localparam int POS_OFFSET    = 2;
	localparam int POS_COUNT     = 3;
	localparam int POS_USED_LO   = 12;
	localparam int POS_USED_HI   = 13;
	localparam int POS_ALLOC_LO  = 14;
	localparam int POS_ALLOC_HI  = 15;

endpackage

FILE: src/nrf_ram.sv
module nrf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Hold read data until the next read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: src/ntfs_record_fixup.sv
// Pipeline: an accepted beat is registered in stage 1, then in the output register
//   that drives fix_valid; fix_stall can hold it in either.
// Throughput: one beat per cycle while the sink does not stall; the header checks,
//   the array capture and the sector-end compare all settle in the accept cycle,
//   and the array RAM read for a replacement overlaps the following cycle.
// Reset: arst_n clears all control and per-record state; the array RAM is not
//   cleared, as each record rewrites its entries before any sector end reads them.
module ntfs_record_fixup import nrf_pkg::*; #(
	parameter int SECTOR_WORDS      = 256,
	parameter int MAX_ARRAY_ENTRIES = 16,
	parameter int MAX_RECORD_WORDS  = 2048
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rec_valid,
	output logic      rec_stall,
	input  rec_beat_t rec_data,
	output logic      fix_valid,
	input  logic      fix_stall,
	output fix_beat_t fix_data
);

	localparam int POS_W        = $clog2(MAX_RECORD_WORDS + 1);
	localparam int OFF_W        = $clog2(SECTOR_WORDS);
	localparam int SEC_W        = $clog2(MAX_RECORD_WORDS / SECTOR_WORDS + 2);
	localparam int BASE_W       = $clog2(2 * MAX_RECORD_WORDS + 1);
	localparam int NEED_W       = 17 + $clog2(SECTOR_WORDS);
	localparam int ADDR_W       = $clog2(MAX_ARRAY_ENTRIES);
	localparam int SECTOR_BYTES = 2 * SECTOR_WORDS;

	// ---------------------------------------------------------------------
	// Per-record state
	// ---------------------------------------------------------------------
	logic [POS_W-1:0]  pos_q;       // word position, saturates at the record limit
	logic [OFF_W-1:0]  off_q;       // word offset inside the current sector
	logic [SEC_W-1:0]  sec_q;       // index of the current sector
	logic [BASE_W-1:0] base_q;      // byte offset of the current sector start
	logic [15:0]       offset_q;    // array offset in bytes
	logic [15:0]       cnt_q;       // array entry count
	logic [31:0]       used_q;      // bytes in use
	logic [15:0]       alloc_lo_q;  // low half of bytes allocated
	logic [NEED_W-1:0] need_q;      // bytes the covered sectors span past the first
	logic [15:0]       check_q;     // check word, array entry 0
	logic              stopped_q;   // fixing stopped past the bytes in use
	logic [2:0]        err_q;       // first error of the record

	logic              acc;
	logic [15:0]       w;
	logic              active;
	logic [14:0]       first;
	logic [15:0]       pos16;
	logic [15:0]       idx16;
	logic              in_body;
	logic              wr_hit;
	logic              sec_end;
	logic [SEC_W-1:0]  j;
	logic              fix_slot;
	logic              match;
	logic              rd_hit;
	logic              mismatch_in_use;
	logic              stop_now;
	logic [2:0]        hdr_err;
	logic [2:0]        err_nxt;
	logic [2:0]        status;

	// ---------------------------------------------------------------------
	// Pipeline: stage 1 waits on the RAM read, the output register faces the sink
	// ---------------------------------------------------------------------
	logic        s1_valid_q;
	logic [15:0] s1_word_q;
	logic        s1_final_q;
	logic [2:0]  s1_status_q;
	logic        s1_sub_q;      // replace the word by the RAM read data
	logic        s1_adv;
	logic        fix_valid_q;
	fix_beat_t   fix_data_q;
	logic [15:0] ram_rd_data;

	assign acc   = rec_valid & ~rec_stall;
	assign w     = rec_data.record_word;
	assign active = pos_q < POS_W'(MAX_RECORD_WORDS);
	assign first = offset_q[15:1];
	assign pos16 = 16'(pos_q);
	assign idx16 = pos16 - {1'b0, first};

	// Body words are handled only once the header passed clean
	assign in_body = active && (pos_q >= POS_W'(HEADER_WORDS)) && (err_q == ST_OK);

	// Capture the update sequence array as it streams by
	assign wr_hit = in_body && (pos16 >= {1'b0, first}) && (idx16 < cnt_q)
		&& (idx16 < 16'(MAX_ARRAY_ENTRIES));

	// Last word of a sector covered by the array
	assign sec_end  = off_q == OFF_W'(SECTOR_WORDS - 1);
	assign j        = sec_q + SEC_W'(1);
	assign fix_slot = in_body && !stopped_q && sec_end && (16'(j) < cnt_q)
		&& (16'(j) < 16'(MAX_ARRAY_ENTRIES));
	assign match    = w == check_q;
	assign rd_hit   = fix_slot && match;

	// A mismatch inside the bytes in use fails the record; past them, fixing stops
	assign mismatch_in_use = fix_slot && !match && (32'(base_q) <= used_q);
	assign stop_now        = fix_slot && !match && !(32'(base_q) <= used_q);

	// Header checks, evaluated on the word that completes bytes allocated
	always_comb begin
		hdr_err = ST_OK;
		if (cnt_q == 16'd0) begin
			hdr_err = ST_BAD_ARRAY;
		end else if ({w, alloc_lo_q} < 32'(need_q)) begin
			hdr_err = ST_ALLOC;
		end else if ((cnt_q > 16'(MAX_ARRAY_ENTRIES)) || (first < 15'(HEADER_WORDS))
			|| ((17'(first) + 17'(cnt_q)) > 17'(SECTOR_WORDS - 1))) begin
			hdr_err = ST_BAD_ARRAY;
		end
	end

	// First error wins
	always_comb begin
		err_nxt = err_q;
		if (active && (err_q == ST_OK)) begin
			if ((pos_q == POS_W'(0)) && (w != SIG_WORD0)) begin
				err_nxt = ST_NO_FILE;
			end
			if ((pos_q == POS_W'(1)) && (w != SIG_WORD1)) begin
				err_nxt = ST_NO_FILE;
			end
			if (pos_q == POS_W'(POS_ALLOC_HI)) begin
				err_nxt = hdr_err;
			end
			if (mismatch_in_use) begin
				err_nxt = ST_MISMATCH;
			end
		end
	end

	// Status is meaningful on the last beat only; a record too short for
	// its header reports a missing signature
	always_comb begin
		status = ST_OK;
		if (rec_data.final_word) begin
			if (err_nxt != ST_OK) begin
				status = err_nxt;
			end else if (pos_q < POS_W'(HEADER_WORDS - 1)) begin
				status = ST_NO_FILE;
			end
		end
	end

	// Track the bytes the array must cover; cnt_q settles long before word 15
	always_ff @(posedge clk) begin
		need_q <= NEED_W'(cnt_q - 16'd1) * NEED_W'(SECTOR_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			off_q      <= '0;
			sec_q      <= '0;
			base_q     <= '0;
			offset_q   <= '0;
			cnt_q      <= '0;
			used_q     <= '0;
			alloc_lo_q <= '0;
			check_q    <= '0;
			stopped_q  <= 1'b0;
			err_q      <= ST_OK;
		end else if (acc) begin
			if (rec_data.final_word) begin
				// Drop all per-record state at the end of the record
				pos_q      <= '0;
				off_q      <= '0;
				sec_q      <= '0;
				base_q     <= '0;
				offset_q   <= '0;
				cnt_q      <= '0;
				used_q     <= '0;
				alloc_lo_q <= '0;
				check_q    <= '0;
				stopped_q  <= 1'b0;
				err_q      <= ST_OK;
			end else if (active) begin
				pos_q <= pos_q + POS_W'(1);
				if (sec_end) begin
					off_q  <= '0;
					sec_q  <= sec_q + SEC_W'(1);
					base_q <= base_q + BASE_W'(SECTOR_BYTES);
				end else begin
					off_q <= off_q + OFF_W'(1);
				end
				case (pos_q)
					POS_W'(POS_OFFSET):   offset_q      <= w;
					POS_W'(POS_COUNT):    cnt_q         <= w;
					POS_W'(POS_USED_LO):  used_q[15:0]  <= w;
					POS_W'(POS_USED_HI):  used_q[31:16] <= w;
					POS_W'(POS_ALLOC_LO): alloc_lo_q    <= w;
					default: ;
				endcase
				if (wr_hit && (idx16 == 16'd0)) begin
					check_q <= w;
				end
				if (stop_now) begin
					stopped_q <= 1'b1;
				end
				err_q <= err_nxt;
			end
		end
	end

	// Array store: written as the array streams by, read at covered sector ends.
	// The array ends before the first sector end, so the two never collide.
	nrf_ram #(
		.WIDTH (16),
		.DEPTH (MAX_ARRAY_ENTRIES)
	) u_array (
		.clk     (clk),
		.wr_en   (acc && wr_hit),
		.wr_addr (ADDR_W'(idx16)),
		.wr_data (w),
		.rd_en   (acc && rd_hit),
		.rd_addr (ADDR_W'(j)),
		.rd_data (ram_rd_data)
	);

	// Advance stage 1 whenever the output register is empty or being taken
	assign s1_adv    = s1_valid_q & (~fix_valid_q | ~fix_stall);
	assign rec_stall = s1_valid_q & ~s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_word_q   <= w;
			s1_final_q  <= rec_data.final_word;
			s1_status_q <= status;
			s1_sub_q    <= rd_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fix_valid_q <= 1'b0;
		end else if (s1_adv) begin
			fix_valid_q <= 1'b1;
		end else if (!fix_stall) begin
			fix_valid_q <= 1'b0;
		end
	end

	// Substitute the array entry for a matching sector-end word
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			fix_data_q.fixed_word   <= s1_sub_q ? ram_rd_data : s1_word_q;
			fix_data_q.final_out    <= s1_final_q;
			fix_data_q.fixup_status <= s1_status_q;
		end
	end

	assign fix_valid = fix_valid_q;
	assign fix_data  = fix_data_q;

`ifndef SYNTHESIS
	// The array capture and the sector-end read never touch the RAM together
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc && wr_hit && rd_hit))
		else $error("array write and read in the same cycle");

	// A failure status shows only on the last beat of a record
	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(fix_valid && (fix_data.fixup_status != ST_OK)) |-> fix_data.final_out)
		else $error("status reported before the last beat");

	// Input stalls only while stage 1 holds a beat it cannot pass on
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		rec_stall |-> (s1_valid_q && fix_valid_q && fix_stall))
		else $error("input stalled without a full pipeline");

	// A new record starts at word zero
	a_record_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && rec_data.final_word) |=> ((pos_q == '0) && (err_q == ST_OK)))
		else $error("record state not cleared after the last beat");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench import nrf_pkg::*;;

	localparam int SECTOR_WORDS = 256;
	localparam int MAX_ENTRIES  = 16;
	localparam int MAX_WORDS    = 512;
	localparam int RANDOM_WORDS = 1400;

	// Tracks the update sequence array state of the record in flight and
	// holds the fixed beats that the block still owes.
	class record_fixup_tracker;
		fix_beat_t   beats_due[$];
		int unsigned fail_count;

		int unsigned pos;
		logic [15:0] arr_off;
		logic [15:0] arr_cnt;
		logic [31:0] used_b;
		logic [31:0] alloc_b;
		logic [15:0] check_word;
		logic [15:0] entries [MAX_ENTRIES];
		bit          stopped;
		logic [2:0]  err;

		function new();
			fail_count = 0;
			foreach (entries[i]) entries[i] = '0;
			clear_record();
		endfunction

		function void clear_record();
			pos = 0;
			arr_off = '0;
			arr_cnt = '0;
			used_b = '0;
			alloc_b = '0;
			check_word = '0;
			stopped = 0;
			err = ST_OK;
		endfunction

		// First error wins
		function void raise(logic [2:0] code);
			if (err == ST_OK) err = code;
		endfunction

		function void check_header();
			int unsigned first;
			int unsigned cnt;
			first = arr_off >> 1;
			cnt = arr_cnt;
			if (cnt == 0) begin
				raise(ST_BAD_ARRAY);
			end else if (longint'(alloc_b) < longint'(cnt - 1) * SECTOR_WORDS * 2) begin
				raise(ST_ALLOC);
			end else if (cnt > MAX_ENTRIES || first < HEADER_WORDS ||
					first + cnt - 1 > SECTOR_WORDS - 2) begin
				raise(ST_BAD_ARRAY);
			end
		endfunction

		function fix_beat_t fix_word(logic [15:0] w, logic is_last);
			fix_beat_t   beat;
			int unsigned p;
			int unsigned first;
			int unsigned idx;
			int unsigned j;
			beat.fixed_word = w;
			beat.final_out = is_last;
			beat.fixup_status = ST_OK;
			p = pos;
			if (p < MAX_WORDS) begin
				case (p)
					0: if (w != SIG_WORD0) raise(ST_NO_FILE);
					1: if (w != SIG_WORD1) raise(ST_NO_FILE);
					POS_OFFSET:   arr_off = w;
					POS_COUNT:    arr_cnt = w;
					POS_USED_LO:  used_b[15:0] = w;
					POS_USED_HI:  used_b[31:16] = w;
					POS_ALLOC_LO: alloc_b[15:0] = w;
					POS_ALLOC_HI: alloc_b[31:16] = w;
					default: ;
				endcase
				if (p == HEADER_WORDS - 1 && err == ST_OK) check_header();
				if (p >= HEADER_WORDS && err == ST_OK) begin
					first = arr_off >> 1;
					if (p >= first) begin
						idx = p - first;
						if (idx < arr_cnt && idx < MAX_ENTRIES) begin
							entries[idx] = w;
							if (idx == 0) check_word = w;
						end
					end
					if (!stopped && (p + 1) % SECTOR_WORDS == 0) begin
						j = (p + 1) / SECTOR_WORDS;
						if (j < arr_cnt && j < MAX_ENTRIES) begin
							if (w == check_word) begin
								beat.fixed_word = entries[j];
							end else if (longint'(j - 1) * SECTOR_WORDS * 2 <=
									longint'(used_b)) begin
								raise(ST_MISMATCH);
							end else begin
								stopped = 1;
							end
						end
					end
				end
				pos = p + 1;
			end
			if (is_last) begin
				if (err != ST_OK) beat.fixup_status = err;
				else if (pos < HEADER_WORDS) beat.fixup_status = ST_NO_FILE;
				clear_record();
			end
			return beat;
		endfunction

		function void note_word(logic [15:0] w, logic is_last);
			beats_due.push_back(fix_word(w, is_last));
		endfunction

		function void check_beat(fix_beat_t got);
			fix_beat_t want;
			if (beats_due.size() == 0) begin
				$error("fixed beat with nothing due: word %h final %b status %0d",
					got.fixed_word, got.final_out, got.fixup_status);
				fail_count++;
				return;
			end
			want = beats_due.pop_front();
			if (got.fixed_word !== want.fixed_word) begin
				$error("fixed_word: expected %h, actual %h", want.fixed_word, got.fixed_word);
				fail_count++;
			end
			if (got.final_out !== want.final_out) begin
				$error("final_out: expected %b, actual %b", want.final_out, got.final_out);
				fail_count++;
			end
			if (got.fixup_status !== want.fixup_status) begin
				$error("fixup_status: expected %0d, actual %0d",
					want.fixup_status, got.fixup_status);
				fail_count++;
			end
		endfunction

		function int unsigned pending();
			return beats_due.size();
		endfunction
	endclass

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      rec_valid = 1'b0;
	logic      rec_stall;
	rec_beat_t rec_data = '0;
	logic      fix_valid;
	logic      fix_stall = 1'b0;
	fix_beat_t fix_data;

	record_fixup_tracker tracker = new();

	logic [15:0] rec_words[$];
	int unsigned burst_left = 0;

	ntfs_record_fixup #(
		.SECTOR_WORDS(SECTOR_WORDS),
		.MAX_ARRAY_ENTRIES(MAX_ENTRIES),
		.MAX_RECORD_WORDS(MAX_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec_stall(rec_stall),
		.rec_data(rec_data),
		.fix_valid(fix_valid),
		.fix_stall(fix_stall),
		.fix_data(fix_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: now and then switch to a randomly chosen stall pattern so
	// back-pressure lands on every phase of a record, with quiet stretches too.
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned mode_left = 0;
	int unsigned stall_cyc = 0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(64, 512);
		end else begin
			mode_left <= mode_left - 1;
		end
		stall_cyc <= stall_cyc + 1;
		case (stall_mode)
			STALL_NONE:     fix_stall <= 1'b0;
			STALL_LIGHT:    fix_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    fix_stall <= ($urandom_range(0, 3) != 0);
			STALL_PERIODIC: fix_stall <= (stall_cyc % 9 < 4);
			default:        fix_stall <= 1'b0;
		endcase
	end

	// Check every fixed beat the receiver takes
	always @(posedge clk) begin
		if (arst_n && fix_valid && !fix_stall) tracker.check_beat(fix_data);
	end

	// Drive one record beat. Entered just after a falling edge; returns just
	// after the falling edge that follows acceptance. The sender works in
	// bursts: at the start of a short burst, drop valid for a random gap.
	task automatic send_beat(input logic [15:0] w, input logic is_last);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				burst_left = $urandom_range(100, 400);
			end else begin
				burst_left = $urandom_range(1, 40);
				gap = $urandom_range(1, 8);
			end
		end
		burst_left--;
		if (gap != 0) begin
			rec_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rec_valid <= 1'b1;
		rec_data <= '{record_word: w, final_word: is_last};
		// Hold the beat until an edge sees it unstalled
		do @(posedge clk); while (rec_stall);
		tracker.note_word(w, is_last);
		@(negedge clk);
	endtask

	task automatic send_record();
		foreach (rec_words[i]) send_beat(rec_words[i], i == rec_words.size() - 1);
	endtask

	// Overwrite one word of the record being built, if the record reaches it
	function automatic void put(int unsigned idx, logic [15:0] val);
		if (idx < rec_words.size()) rec_words[idx] = val;
	endfunction

	// Build a record with the standard header. Most come out well formed;
	// the rest carry a zero count, an oversized count, a misplaced array or
	// too small an allocated size. Sector-end words mostly hold the check word.
	function automatic void make_structured(int unsigned len, bit legal_only);
		int unsigned variant;
		int unsigned nsect;
		int unsigned c;
		int unsigned first;
		logic [31:0] used_v;
		logic [31:0] alloc_v;
		logic [15:0] chk;
		rec_words.delete();
		for (int i = 0; i < len; i++) rec_words.push_back(16'($urandom()));
		variant = legal_only ? 0 : $urandom_range(0, 9);
		nsect = (len + SECTOR_WORDS - 1) / SECTOR_WORDS;
		if ($urandom_range(0, 2) == 0) c = $urandom_range(1, MAX_ENTRIES);
		else c = (nsect + 1 < MAX_ENTRIES) ? nsect + 1 : MAX_ENTRIES;
		first = $urandom_range(HEADER_WORDS, SECTOR_WORDS - 1 - c);
		alloc_v = (c - 1) * SECTOR_WORDS * 2 + $urandom_range(0, 2048);
		used_v = $urandom_range(0, len * 2);
		case (variant)
			6: c = 0;
			7: begin
				c = $urandom_range(MAX_ENTRIES + 1, 65535);
				alloc_v = ($urandom_range(0, 3) != 0) ? 32'hFFFF_FFFF : $urandom();
			end
			8: begin
				if ($urandom_range(0, 1) == 0) first = $urandom_range(0, HEADER_WORDS - 1);
				else first = $urandom_range(SECTOR_WORDS - c, 32767);
			end
			9: begin
				if (c < 2) c = $urandom_range(2, MAX_ENTRIES);
				alloc_v = (c - 1) * SECTOR_WORDS * 2 - $urandom_range(1, 512);
			end
			default: ;
		endcase
		chk = $urandom();
		// Misplaced arrays may sit inside the header; leave it intact there
		if (variant != 8) put(first, chk);
		for (int j = 1; j < c && j < MAX_ENTRIES; j++)
			put(j * SECTOR_WORDS - 1, ($urandom_range(0, 7) != 0) ? chk : 16'($urandom()));
		put(0, SIG_WORD0);
		put(1, SIG_WORD1);
		put(POS_OFFSET, 16'(first * 2 + $urandom_range(0, 1)));
		put(POS_COUNT, 16'(c));
		put(POS_USED_LO, used_v[15:0]);
		put(POS_USED_HI, used_v[31:16]);
		put(POS_ALLOC_LO, alloc_v[15:0]);
		put(POS_ALLOC_HI, alloc_v[31:16]);
		// Now and then break the signature
		if (!legal_only && $urandom_range(0, 19) == 0)
			put($urandom_range(0, 1), 16'($urandom()));
	endfunction

	// Short junk record, sometimes with part or all of the signature
	function automatic void make_noise();
		int unsigned len;
		len = $urandom_range(1, 24);
		rec_words.delete();
		for (int i = 0; i < len; i++) rec_words.push_back(16'($urandom()));
		if ($urandom_range(0, 1) == 1) put(0, SIG_WORD0);
		if ($urandom_range(0, 1) == 1) put(1, SIG_WORD1);
	endfunction

	initial begin
		int unsigned random_words;
		int unsigned rec_idx;
		int unsigned long_at;
		int unsigned sel;
		int unsigned len;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: a one-word record of all ones, an all-zero record,
		// a good signature that ends inside the header, and a zero count.
		rec_words = '{16'hFFFF};
		send_record();
		rec_words = '{16'h0000, 16'h0000};
		send_record();
		rec_words = '{SIG_WORD0, SIG_WORD1, 16'h0030, 16'h0002, 16'hFFFF, 16'h0000};
		send_record();
		rec_words = '{SIG_WORD0, SIG_WORD1, 16'h0030, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
		send_record();

		// Random records; one of them runs past the maximum record length
		random_words = 0;
		rec_idx = 0;
		long_at = $urandom_range(0, 2);
		while (random_words < RANDOM_WORDS) begin
			if (rec_idx == long_at) begin
				make_structured(MAX_WORDS + $urandom_range(1, 8), 1);
			end else begin
				if ($urandom_range(0, 3) == 0) begin
					make_noise();
				end else begin
					sel = $urandom_range(0, 9);
					if (sel < 4) len = $urandom_range(256, 560);
					else if (sel < 8) len = $urandom_range(16, 64);
					else len = $urandom_range(1, 15);
					make_structured(len, 0);
				end
			end
			random_words += rec_words.size();
			send_record();
			rec_idx++;
		end
		rec_valid <= 1'b0;

		// Drain, then let the pipeline settle
		while (tracker.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (tracker.fail_count == 0 && tracker.pending() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
src/nrf_pkg.sv
src/nrf_ram.sv
src/ntfs_record_fixup.sv
sim/testbench.sv
